FILE: sv/least_squares_line_fit_assert.svh
// assertion macros for the line fit checker
`ifndef LEAST_SQUARES_LINE_FIT_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LSLF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LSLF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lslf_pkg.sv
// types, widths and codes shared by the line fit block
`timescale 1ns / 1ps
`default_nettype none

package lslf_pkg;

    // largest number of points in one set
    localparam int MAX_POINTS = 32;
    localparam int MIN_POINTS = 2;

    // field widths
    localparam int X_W    = 24;
    localparam int Y_W    = 32;
    localparam int OUT_W  = 64;
    localparam int STAT_W = 2;

    // accumulator widths follow from the set size
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int LOG_MP = $clog2(MAX_POINTS);
    localparam int SX_W   = X_W + LOG_MP;
    localparam int SY_W   = Y_W + LOG_MP;
    localparam int SXX_W  = 2 * X_W + LOG_MP;
    localparam int SXY_W  = X_W + Y_W + LOG_MP;

    // fit datapath
    localparam int HALF_W    = 32;
    localparam int OP_W      = 2 * HALF_W;
    localparam int ACC_W     = 2 * OP_W;
    localparam int DIV_CNT_W = $clog2(ACC_W);
    localparam int NS_SHIFT  = 28;
    localparam int NI_SHIFT  = 16;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FEW      = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ZERO_DEN = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_TOO_MANY = 2'd3;

    // one calibration point
    typedef struct packed {
        logic signed [X_W-1:0] x_value;
        logic [Y_W-1:0]        y_reading;
        logic                  last_point;
    } point_t;

    // one fit result
    typedef struct packed {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] intercept;
        logic [STAT_W-1:0]       fit_status;
    } fit_t;

endpackage

`default_nettype wire

FILE: sv/lslf_mul.sv
// shared registered 32 x 32 unsigned multiplier
`timescale 1ns / 1ps
`default_nettype none

module lslf_mul (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [lslf_pkg::HALF_W-1:0]     a,
    input  wire logic [lslf_pkg::HALF_W-1:0]     b,
    output logic      [lslf_pkg::OP_W-1:0]       prod
);

    logic [lslf_pkg::OP_W-1:0] prod_reg;

    // product register, loaded when the sequencer issues an operation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= lslf_pkg::OP_W'(a) * lslf_pkg::OP_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/least_squares_line_fit.sv
// least-squares line fit: point accumulation, fit sequencer and divider
// a point that does not close the set passes through the accumulate state, then start is taken again
// the closing point runs the fit sequence and ends with done; too few or too many points
// stop it at the check, a zero denominator at its capture; it holds two 128-step bit-serial divisions
// every product goes through one shared 32 x 32 multiplier, 4 partial products per pair
// reset clears the sums, the count and the sequencer; the receiver cannot stall done
`timescale 1ns / 1ps
`default_nettype none

module least_squares_line_fit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire lslf_pkg::point_t point,
    output logic                  done,
    output lslf_pkg::fit_t        fit
);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ACC   = 4'd1;
    localparam logic [3:0] ST_CHECK = 4'd2;
    localparam logic [3:0] ST_PREP  = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_DRAIN = 4'd5;
    localparam logic [3:0] ST_DCAP  = 4'd6;
    localparam logic [3:0] ST_NEG   = 4'd7;
    localparam logic [3:0] ST_SHIFT = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_SAT   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    localparam int HW  = lslf_pkg::HALF_W;
    localparam int OW  = lslf_pkg::OP_W;
    localparam int AW  = lslf_pkg::ACC_W;
    localparam int VW  = lslf_pkg::OUT_W;
    localparam logic [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

    // control state
    logic [3:0]                          state_reg, state_next;
    logic [lslf_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                                ovf_reg, ovf_next;
    logic                                pend_reg, pend_next;
    logic                                ppv_reg, ppv_next;
    logic [1:0]                          grp_reg, grp_next;
    logic [2:0]                          step_reg, step_next;
    logic [lslf_pkg::DIV_CNT_W-1:0]      bit_reg, bit_next;

    // running sums
    logic [lslf_pkg::SX_W-1:0]           sx_reg, sx_next;
    logic [lslf_pkg::SY_W-1:0]           sy_reg, sy_next;
    logic [lslf_pkg::SXX_W-1:0]          sxx_reg, sxx_next;
    logic [lslf_pkg::SXY_W-1:0]          sxy_reg, sxy_next;

    // payload registers
    logic [lslf_pkg::X_W-1:0]            x_reg, x_next;
    logic [lslf_pkg::X_W-1:0]            xmag_reg, xmag_next;
    logic                                xneg_reg, xneg_next;
    logic [lslf_pkg::Y_W-1:0]            y_reg, y_next;
    logic                                last_reg, last_next;
    logic                                take_reg, take_next;
    logic                                pneg_reg, pneg_next;
    logic                                sxneg_reg, sxneg_next;
    logic                                sxyneg_reg, sxyneg_next;
    logic                                ppneg_reg, ppneg_next;
    logic [1:0]                          ppsh_reg, ppsh_next;
    logic [AW-1:0]                       acc_reg, acc_next;
    logic [OW-1:0]                       den_reg, den_next;
    logic [OW-1:0]                       rem_reg, rem_next;
    logic                                numneg_reg, numneg_next;
    logic [VW-1:0]                       slope_reg, slope_next;
    logic [VW-1:0]                       icpt_reg, icpt_next;
    logic [lslf_pkg::STAT_W-1:0]         status_reg, status_next;

    // datapath nets
    logic                                accept;
    logic [lslf_pkg::X_W-1:0]            xin_mag;
    logic                                mul_en;
    logic [HW-1:0]                       mul_a, mul_b;
    logic [OW-1:0]                       prod;
    logic [OW-1:0]                       op_a, op_b;
    logic                                term_neg;
    logic [AW-1:0]                       pp_ext;
    logic [OW:0]                         div_shift;
    logic [OW+1:0]                       div_diff;
    logic                                qbit;
    logic [VW-1:0]                       sat_val;
    logic [AW-VW-1:0]                    q_hi;
    logic [VW-1:0]                       q_lo;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = (state_reg == ST_OUT);
    assign xin_mag = point.x_value[lslf_pkg::X_W-1] ? (~point.x_value + 1'b1) : point.x_value;

    // operand pair for the current term of the fit
    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        term_neg = 1'b0;
        case ({grp_reg, step_reg[2]})
            3'd0:
            begin
                op_a     = OW'(cnt_reg);
                op_b     = OW'(sxx_reg);
                term_neg = 1'b0;
            end
            3'd1:
            begin
                op_a     = OW'(sx_reg);
                op_b     = OW'(sx_reg);
                term_neg = 1'b1;
            end
            3'd2:
            begin
                op_a     = OW'(cnt_reg);
                op_b     = OW'(sxy_reg);
                term_neg = sxyneg_reg;
            end
            3'd3:
            begin
                op_a     = OW'(sx_reg);
                op_b     = OW'(sy_reg);
                term_neg = !sxneg_reg;
            end
            3'd4:
            begin
                op_a     = OW'(sxx_reg);
                op_b     = OW'(sy_reg);
                term_neg = 1'b0;
            end
            3'd5:
            begin
                op_a     = OW'(sx_reg);
                op_b     = OW'(sxy_reg);
                term_neg = !(sxneg_reg ^ sxyneg_reg);
            end
            default:
            begin
                op_a     = '0;
                op_b     = '0;
                term_neg = 1'b0;
            end
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_en = accept;
                mul_a  = HW'(xin_mag);
                mul_b  = HW'(xin_mag);
            end
            ST_ACC:
            begin
                mul_en = 1'b1;
                mul_a  = HW'(xmag_reg);
                mul_b  = y_reg;
            end
            ST_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = op_a[step_reg[1]*HW +: HW];
                mul_b  = op_b[step_reg[0]*HW +: HW];
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    lslf_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // partial product aligned to its chunk position
    always_comb
    begin
        case (ppsh_reg)
            2'd0:    pp_ext = AW'(prod);
            2'd1:    pp_ext = AW'(prod) << HW;
            2'd2:    pp_ext = AW'(prod) << (2 * HW);
            default: pp_ext = '0;
        endcase
    end

    // one restoring division step
    assign div_shift = {rem_reg, acc_reg[AW-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, den_reg};
    assign qbit      = !div_diff[OW+1];

    // saturate the quotient to the signed output range
    assign q_hi = acc_reg[AW-1:VW];
    assign q_lo = acc_reg[VW-1:0];
    always_comb
    begin
        if (numneg_reg)
        begin
            if ((q_hi != '0) || (q_lo > SAT_MIN))
            begin
                sat_val = SAT_MIN;
            end
            else
            begin
                sat_val = ~q_lo + 1'b1;
            end
        end
        else
        begin
            if ((q_hi != '0) || q_lo[VW-1])
            begin
                sat_val = SAT_MAX;
            end
            else
            begin
                sat_val = q_lo;
            end
        end
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        pend_next   = 1'b0;
        ppv_next    = 1'b0;
        grp_next    = grp_reg;
        step_next   = step_reg;
        bit_next    = bit_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sxx_next    = sxx_reg;
        sxy_next    = sxy_reg;
        x_next      = x_reg;
        xmag_next   = xmag_reg;
        xneg_next   = xneg_reg;
        y_next      = y_reg;
        last_next   = last_reg;
        take_next   = take_reg;
        pneg_next   = pneg_reg;
        sxneg_next  = sxneg_reg;
        sxyneg_next = sxyneg_reg;
        ppneg_next  = ppneg_reg;
        ppsh_next   = ppsh_reg;
        acc_next    = acc_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        numneg_next = numneg_reg;
        slope_next  = slope_reg;
        icpt_next   = icpt_reg;
        status_next = status_reg;

        // deferred x*y add from the previous point
        if (pend_reg)
        begin
            sxy_next = pneg_reg ? (sxy_reg - lslf_pkg::SXY_W'(prod))
                                : (sxy_reg + lslf_pkg::SXY_W'(prod));
        end

        // accumulate the previous partial product
        if (ppv_reg)
        begin
            acc_next = ppneg_reg ? (acc_reg - pp_ext) : (acc_reg + pp_ext);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next     = point.x_value;
                    xmag_next  = xin_mag;
                    xneg_next  = point.x_value[lslf_pkg::X_W-1];
                    y_next     = point.y_reading;
                    last_next  = point.last_point;
                    take_next  = !ovf_reg &&
                                 (cnt_reg < lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS));
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (take_reg)
                begin
                    sx_next  = sx_reg + {{(lslf_pkg::SX_W-lslf_pkg::X_W){x_reg[lslf_pkg::X_W-1]}},
                                         x_reg};
                    sy_next  = sy_reg + lslf_pkg::SY_W'(y_reg);
                    sxx_next = sxx_reg + lslf_pkg::SXX_W'(prod);
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                pend_next  = take_reg;
                pneg_next  = xneg_reg;
                state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                slope_next  = '0;
                icpt_next   = '0;
                status_next = lslf_pkg::STATUS_OK;
                if (ovf_reg)
                begin
                    status_next = lslf_pkg::STATUS_TOO_MANY;
                    state_next  = ST_OUT;
                end
                else if (cnt_reg < lslf_pkg::CNT_W'(lslf_pkg::MIN_POINTS))
                begin
                    status_next = lslf_pkg::STATUS_FEW;
                    state_next  = ST_OUT;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // signed sums go to sign and magnitude for the multiplier
                sxneg_next  = sx_reg[lslf_pkg::SX_W-1];
                sx_next     = sx_reg[lslf_pkg::SX_W-1] ? (~sx_reg + 1'b1) : sx_reg;
                sxyneg_next = sxy_reg[lslf_pkg::SXY_W-1];
                sxy_next    = sxy_reg[lslf_pkg::SXY_W-1] ? (~sxy_reg + 1'b1) : sxy_reg;
                acc_next    = '0;
                grp_next    = 2'd0;
                step_next   = '0;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                ppv_next   = 1'b1;
                ppneg_next = term_neg;
                ppsh_next  = 2'(step_reg[1]) + 2'(step_reg[0]);
                step_next  = step_reg + 1'b1;
                if (step_reg == 3'd7)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = (grp_reg == 2'd0) ? ST_DCAP : ST_NEG;
            end
            ST_DCAP:
            begin
                den_next = acc_reg[OW-1:0];
                if (acc_reg == '0)
                begin
                    status_next = lslf_pkg::STATUS_ZERO_DEN;
                    state_next  = ST_OUT;
                end
                else
                begin
                    acc_next   = '0;
                    grp_next   = 2'd1;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_NEG:
            begin
                numneg_next = acc_reg[AW-1];
                acc_next    = acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;
                state_next  = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // scale the numerator and add half the divisor for rounding
                acc_next   = ((grp_reg == 2'd1) ? (acc_reg << lslf_pkg::NS_SHIFT)
                                                : (acc_reg << lslf_pkg::NI_SHIFT))
                             + AW'(den_reg >> 1);
                rem_next   = '0;
                bit_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                acc_next = {acc_reg[AW-2:0], qbit};
                rem_next = qbit ? div_diff[OW-1:0] : div_shift[OW-1:0];
                bit_next = bit_reg + 1'b1;
                if (bit_reg == lslf_pkg::DIV_CNT_W'(AW - 1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (grp_reg == 2'd1)
                begin
                    slope_next = sat_val;
                    acc_next   = '0;
                    grp_next   = 2'd2;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    icpt_next  = sat_val;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                cnt_next   = '0;
                ovf_next   = 1'b0;
                sx_next    = '0;
                sy_next    = '0;
                sxx_next   = '0;
                sxy_next   = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            ppv_reg   <= 1'b0;
            grp_reg   <= '0;
            step_reg  <= '0;
            bit_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            sxy_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            ppv_reg   <= ppv_next;
            grp_reg   <= grp_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sxx_reg   <= sxx_next;
            sxy_reg   <= sxy_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        xmag_reg   <= xmag_next;
        xneg_reg   <= xneg_next;
        y_reg      <= y_next;
        last_reg   <= last_next;
        take_reg   <= take_next;
        pneg_reg   <= pneg_next;
        sxneg_reg  <= sxneg_next;
        sxyneg_reg <= sxyneg_next;
        ppneg_reg  <= ppneg_next;
        ppsh_reg   <= ppsh_next;
        acc_reg    <= acc_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        numneg_reg <= numneg_next;
        slope_reg  <= slope_next;
        icpt_reg   <= icpt_next;
        status_reg <= status_next;
    end

    // result word
    assign fit.slope      = slope_reg;
    assign fit.intercept  = icpt_reg;
    assign fit.fit_status = status_reg;

endmodule

`default_nettype wire

FILE: sv/lslf_checker.sv
// port-level checks for the line fit block, attached by bind
`timescale 1ns / 1ps
`default_nettype none

`include "least_squares_line_fit_assert.svh"

module lslf_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire lslf_pkg::point_t point,
    input wire logic             done,
    input wire lslf_pkg::fit_t   fit
);

    // a result word only appears while a fit is in progress
    `LSLF_ASSERT_IMP(a_done_busy, done, busy, "done without busy")

    // the block is free again right after a result word
    `LSLF_ASSERT_NXT(a_done_frees, done, !busy, "busy held after done")

    // a point that does not close the set is absorbed while busy, with no result, then the block is free
    `LSLF_ASSERT_IMP(a_point_two_cycles, start && !busy && !point.last_point, ##1 (busy && !done) ##1 !busy, "open-set point not absorbed in two cycles")

    // any failed fit reports zero slope and intercept
    `LSLF_ASSERT_IMP(a_fail_zero, done && (fit.fit_status != lslf_pkg::STATUS_OK), (fit.slope == '0) && (fit.intercept == '0), "failed fit with nonzero values")

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .point (point),
    .done  (done),
    .fit   (fit)
);

`default_nettype wire

FILE: verif/least_squares_line_fit_test.sv
// self-checking testbench for the least-squares line fit block
`timescale 1ns / 1ps

module least_squares_line_fit_test;

    localparam int ITEM_TARGET  = 1050;
    localparam int SETTLE_CYCLES = 320;

    localparam logic [lslf_pkg::X_W-1:0]   X_MAX   = 24'h7F_FFFF;
    localparam logic [lslf_pkg::X_W-1:0]   X_MIN   = 24'h80_0000;
    localparam logic [lslf_pkg::Y_W-1:0]   Y_MAX   = 32'hFFFF_FFFF;
    localparam logic [lslf_pkg::OUT_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [lslf_pkg::OUT_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

    typedef enum bit {CHK_MODEL, CHK_TYPED} row_check_t;

    typedef struct {
        lslf_pkg::point_t pt;
        row_check_t       how;
        lslf_pkg::fit_t   want;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    lslf_pkg::point_t point;
    logic             done;
    lslf_pkg::fit_t   fit;

    // fitter state mirrored by the testbench
    int                  held_points;
    bit                  set_overflowed;
    logic signed [127:0] sum_x_acc;
    logic signed [127:0] sum_y_acc;
    logic signed [127:0] sum_xx_acc;
    logic signed [127:0] sum_xy_acc;

    lslf_pkg::fit_t pending_fits[$];
    stim_row_t      directed_rows[$];
    int             err_count;
    int             points_sent;
    int             status_tally[4];

    least_squares_line_fit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .point (point),
        .done  (done),
        .fit   (fit)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop if the block hangs
    initial
    begin
        #30_000_000;
        $display("least_squares_line_fit_test: done, errors");
        $finish;
    end

    // rounded division of a signed numerator by a positive denominator, saturated
    function automatic logic [lslf_pkg::OUT_W-1:0] div_round_sat(
        input logic signed [127:0] num,
        input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] dd;
        logic [127:0] q;
        dd  = den;
        mag = num[127] ? -num : num;
        q   = (mag + (dd >> 1)) / dd;
        if (num[127])
        begin
            if (q > {64'd0, SAT_MIN})
                return SAT_MIN;
            return -q[lslf_pkg::OUT_W-1:0];
        end
        if (q > {64'd0, SAT_MAX})
            return SAT_MAX;
        return q[lslf_pkg::OUT_W-1:0];
    endfunction

    // fold one point into the sums; on the closing point compute the fit
    function automatic bit fold_point(input lslf_pkg::point_t p, output lslf_pkg::fit_t r);
        logic signed [127:0] xw;
        logic signed [127:0] yw;
        logic signed [127:0] nn;
        logic signed [127:0] den;
        logic signed [127:0] ns;
        logic signed [127:0] ni;
        r  = '0;
        xw = 128'($signed(p.x_value));
        yw = {96'd0, p.y_reading};
        if (!set_overflowed)
        begin
            if (held_points < lslf_pkg::MAX_POINTS)
            begin
                sum_x_acc   = sum_x_acc + xw;
                sum_y_acc   = sum_y_acc + yw;
                sum_xx_acc  = sum_xx_acc + xw * xw;
                sum_xy_acc  = sum_xy_acc + xw * yw;
                held_points = held_points + 1;
            end
            else
                set_overflowed = 1'b1;
        end
        if (!p.last_point)
            return 1'b0;
        if (set_overflowed)
            r.fit_status = lslf_pkg::STATUS_TOO_MANY;
        else if (held_points < lslf_pkg::MIN_POINTS)
            r.fit_status = lslf_pkg::STATUS_FEW;
        else
        begin
            nn  = 128'(held_points);
            den = nn * sum_xx_acc - sum_x_acc * sum_x_acc;
            if (den == 0)
                r.fit_status = lslf_pkg::STATUS_ZERO_DEN;
            else
            begin
                ns = (nn * sum_xy_acc - sum_x_acc * sum_y_acc) <<< lslf_pkg::NS_SHIFT;
                ni = (sum_xx_acc * sum_y_acc - sum_x_acc * sum_xy_acc) <<< lslf_pkg::NI_SHIFT;
                r.slope      = div_round_sat(ns, den);
                r.intercept  = div_round_sat(ni, den);
                r.fit_status = lslf_pkg::STATUS_OK;
            end
        end
        held_points    = 0;
        set_overflowed = 1'b0;
        sum_x_acc      = '0;
        sum_y_acc      = '0;
        sum_xx_acc     = '0;
        sum_xy_acc     = '0;
        return 1'b1;
    endfunction

    // hand one word to the block, then idle, drain or go straight on
    task automatic send_point(input lslf_pkg::point_t p, input row_check_t how,
                              input lslf_pkg::fit_t want, input bit drain, input bit quiet);
        lslf_pkg::fit_t pred;
        int             pick;
        int             gap;
        start <= 1'b1;
        point <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        points_sent++;
        if (fold_point(p, pred))
        begin
            if (how == CHK_TYPED)
                pred = want;
            pending_fits.push_back(pred);
            status_tally[pred.fit_status]++;
        end
        if (drain)
        begin
            start <= 1'b0;
            while (pending_fits.size() != 0)
                @(posedge clk);
        end
        else if (!quiet)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                gap = 0;
            else if (pick < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 40);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic add_row(input logic [lslf_pkg::X_W-1:0] x,
                           input logic [lslf_pkg::Y_W-1:0] y, input bit last,
                           input row_check_t how, input logic [lslf_pkg::OUT_W-1:0] slope,
                           input logic [lslf_pkg::OUT_W-1:0] icpt,
                           input logic [lslf_pkg::STAT_W-1:0] status);
        stim_row_t row;
        row.pt.x_value      = x;
        row.pt.y_reading    = y;
        row.pt.last_point   = last;
        row.how             = how;
        row.want.slope      = slope;
        row.want.intercept  = icpt;
        row.want.fit_status = status;
        directed_rows.push_back(row);
    endtask

    // one random calibration set of the given length
    task automatic send_set(input int len, input bit drain);
        lslf_pkg::point_t         p;
        int                       xstyle;
        int                       ystyle;
        int                       i;
        bit                       quiet;
        logic [lslf_pkg::X_W-1:0] base;
        logic [lslf_pkg::Y_W-1:0] y0;
        logic [lslf_pkg::Y_W-1:0] ystep;
        xstyle = $urandom_range(0, 9);
        ystyle = $urandom_range(0, 3);
        base   = lslf_pkg::X_W'($urandom());
        y0     = $urandom();
        ystep  = $urandom_range(0, 5000);
        quiet  = ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++)
        begin
            if (xstyle < 5)
                p.x_value = lslf_pkg::X_W'($urandom());
            else if (xstyle < 8)
                p.x_value = base + 24'($urandom_range(0, 63));
            else if (xstyle == 8)
                p.x_value = base;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       p.x_value = X_MAX;
                    1:       p.x_value = X_MIN;
                    2:       p.x_value = '0;
                    default: p.x_value = '1;
                endcase
            end
            case (ystyle)
                0:       p.y_reading = $urandom();
                1:       p.y_reading = y0 + ystep * i + $urandom_range(0, 15);
                2:       p.y_reading = $urandom_range(0, 1) ? Y_MAX : '0;
                default: p.y_reading = $urandom_range(0, 255);
            endcase
            p.last_point = (i == len - 1);
            send_point(p, CHK_MODEL, '0, drain && p.last_point, quiet);
        end
    endtask

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        lslf_pkg::fit_t want;
        if (rst_n && done)
        begin
            if (pending_fits.size() == 0)
            begin
                if (err_count < 10)
                    $display("unexpected result: slope %h intercept %h status %0d",
                             fit.slope, fit.intercept, fit.fit_status);
                err_count++;
            end
            else
            begin
                want = pending_fits.pop_front();
                if (fit.slope !== want.slope || fit.intercept !== want.intercept ||
                    fit.fit_status !== want.fit_status)
                begin
                    if (err_count < 10)
                        $display("mismatch: slope %h/%h intercept %h/%h status %0d/%0d (exp/act)",
                                 want.slope, fit.slope, want.intercept, fit.intercept,
                                 want.fit_status, fit.fit_status);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        lslf_pkg::point_t p;
        lslf_pkg::fit_t   want;
        int               i;
        int               len;
        int               pick;
        int               set_idx;
        bit               final_set;

        rst_n          = 1'b0;
        start          = 1'b0;
        point          = '0;
        err_count      = 0;
        points_sent    = 0;
        held_points    = 0;
        set_overflowed = 1'b0;
        sum_x_acc      = '0;
        sum_y_acc      = '0;
        sum_xx_acc     = '0;
        sum_xy_acc     = '0;
        for (i = 0; i < 4; i++)
            status_tally[i] = 0;

        // single point, repeated x, extremes, saturation, exact line, small values
        add_row('0, '0, 1'b1, CHK_TYPED, '0, '0, lslf_pkg::STATUS_FEW);
        add_row(X_MAX, Y_MAX, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(X_MAX, '0, 1'b1, CHK_TYPED, '0, '0, lslf_pkg::STATUS_ZERO_DEN);
        add_row(X_MIN, Y_MAX, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(X_MAX, '0, 1'b1, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(X_MIN, '0, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(X_MAX, Y_MAX, 1'b1, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(X_MAX - 24'd1, '0, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(X_MAX, Y_MAX, 1'b1, CHK_TYPED, 64'h0FFF_FFFF_F000_0000, SAT_MIN,
                lslf_pkg::STATUS_OK);
        add_row(X_MAX - 24'd1, Y_MAX, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(X_MAX, '0, 1'b1, CHK_TYPED, 64'hF000_0000_1000_0000, SAT_MAX,
                lslf_pkg::STATUS_OK);
        add_row(24'd4096, 32'd100, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(24'd8192, 32'd200, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(24'd12288, 32'd300, 1'b1, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row('1, 32'd7, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row('0, 32'd3, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(24'd1, 32'd12, 1'b1, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(X_MIN, '0, 1'b1, CHK_TYPED, '0, '0, lslf_pkg::STATUS_FEW);
        add_row(-24'sd5, 32'd9, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(-24'sd5, 32'd1, 1'b0, CHK_MODEL, '0, '0, lslf_pkg::STATUS_OK);
        add_row(-24'sd5, 32'd4, 1'b1, CHK_TYPED, '0, '0, lslf_pkg::STATUS_ZERO_DEN);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[row_idx])
            send_point(directed_rows[row_idx].pt, directed_rows[row_idx].how,
                       directed_rows[row_idx].want, 1'b0, 1'b0);

        // a full set, then one point too many
        for (i = 0; i < lslf_pkg::MAX_POINTS; i++)
        begin
            p.x_value    = lslf_pkg::X_W'($urandom());
            p.y_reading  = $urandom();
            p.last_point = (i == lslf_pkg::MAX_POINTS - 1);
            send_point(p, CHK_MODEL, '0, 1'b0, 1'b0);
        end
        want = '{slope: '0, intercept: '0, fit_status: lslf_pkg::STATUS_TOO_MANY};
        for (i = 0; i <= lslf_pkg::MAX_POINTS; i++)
        begin
            p.x_value    = lslf_pkg::X_W'($urandom());
            p.y_reading  = $urandom();
            p.last_point = (i == lslf_pkg::MAX_POINTS);
            send_point(p, CHK_TYPED, want, p.last_point, 1'b0);
        end

        // random sets, mostly short, some full, a few over the limit
        set_idx   = 0;
        final_set = 1'b0;
        while (!final_set)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = 1;
            else if (pick < 70)
                len = $urandom_range(2, 6);
            else if (pick < 85)
                len = $urandom_range(7, 16);
            else if (pick < 95)
                len = $urandom_range(lslf_pkg::MAX_POINTS - 4, lslf_pkg::MAX_POINTS);
            else
                len = $urandom_range(lslf_pkg::MAX_POINTS + 1, lslf_pkg::MAX_POINTS + 8);
            final_set = (points_sent + len >= ITEM_TARGET);
            send_set(len, final_set || (set_idx % 20 == 19));
            set_idx++;
        end

        // let the block settle, then look for leftovers
        while (pending_fits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_fits.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_fits.size());
            err_count++;
        end

        $display("sent %0d points; fits: %0d ok, %0d too few, %0d equal x, %0d over limit",
                 points_sent, status_tally[lslf_pkg::STATUS_OK],
                 status_tally[lslf_pkg::STATUS_FEW], status_tally[lslf_pkg::STATUS_ZERO_DEN],
                 status_tally[lslf_pkg::STATUS_TOO_MANY]);
        $display("%0d result mismatches or stray results", err_count);
        if (err_count == 0)
            $display("least_squares_line_fit_test: done, clean");
        else
            $display("least_squares_line_fit_test: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/lslf_pkg.sv
sv/lslf_mul.sv
sv/least_squares_line_fit.sv
sv/lslf_checker.sv
verif/least_squares_line_fit_test.sv
